// File: rtl/dcps_pkg.sv
// Shared types and constants for the dual-channel PID speed controller.
// Used by every module under rtl/; depends on nothing.
package dcps_pkg;

  localparam int TARGET_W = 8;
  localparam int GAIN_W   = 16;
  localparam int SUM_W    = 32;
  localparam int DRIVE_W  = 8;
  localparam int CFG_IDX_W = 2;

  localparam int DRIVE_MAX = 100;
  localparam int DRIVE_MIN = -100;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 2'd2;

  // gain reset values, Q4.12 (0.3, 0.1, 0.05)
  localparam logic [GAIN_W-1:0] GAIN_P_RST = 16'd1229;
  localparam logic [GAIN_W-1:0] GAIN_I_RST = 16'd410;
  localparam logic [GAIN_W-1:0] GAIN_D_RST = 16'd205;

  typedef struct packed {
    logic [GAIN_W-1:0] p;
    logic [GAIN_W-1:0] i;
    logic [GAIN_W-1:0] d;
  } gains_t;

  // per-stage load enables shared by all lanes
  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic s3_en;
  } ctrl_t;

endpackage

// File: rtl/dcps_lane.sv
// One PID channel: error/sum stage, multiply stage, accumulate stage, clamp.
// Depends on dcps_pkg; stage enables come from the top level.
module dcps_lane import dcps_pkg::*; #(
  parameter int MEAS_WIDTH     = 16,
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ctrl_t                       ctrl_i,
  input  gains_t                      gains_i,
  input  logic signed [TARGET_W-1:0]  target_i,
  input  logic signed [MEAS_WIDTH-1:0] meas_i,
  output logic signed [DRIVE_W-1:0]   drive_o
);

  localparam int ERR_W  = MEAS_WIDTH + 1;
  localparam int DIFF_W = MEAS_WIDTH + 2;
  localparam int GS_W   = GAIN_W + 1;
  localparam int PP_W   = GS_W + ERR_W;
  localparam int PI_W   = GS_W + SUM_W;
  localparam int PD_W   = GS_W + DIFF_W;
  localparam int PMAX_W = (PD_W > PI_W) ? PD_W : PI_W;
  localparam int ACC_W  = PMAX_W + 2;

  localparam logic signed [ACC_W-1:0] LIM_HI = ACC_W'(DRIVE_MAX);
  localparam logic signed [ACC_W-1:0] LIM_LO = ACC_W'(DRIVE_MIN);

  // channel state
  logic signed [ERR_W-1:0] prev_q;
  logic signed [SUM_W-1:0] esum_q;

  // stage 1 combinational
  logic signed [ERR_W-1:0]  err;
  logic signed [SUM_W:0]    sum_ext;
  logic signed [SUM_W-1:0]  sum_sat;
  logic signed [DIFF_W-1:0] diff;
  logic                     zero;

  // pipeline payload
  logic signed [ERR_W-1:0]  err1_q;
  logic signed [SUM_W-1:0]  sum1_q;
  logic signed [DIFF_W-1:0] diff1_q;
  logic                     zero1_q, zero2_q, zero3_q;
  logic signed [PP_W-1:0]   pp2_q;
  logic signed [PI_W-1:0]   pi2_q;
  logic signed [PD_W-1:0]   pd2_q;
  logic signed [ACC_W-1:0]  acc3_q;

  logic signed [GS_W-1:0]   gp, gi, gd;
  logic signed [ACC_W-1:0]  quot;
  logic signed [ACC_W-1:0]  quot_tz;
  logic signed [DRIVE_W-1:0] clamp;

  always_comb begin
    err     = ERR_W'(target_i) - ERR_W'(meas_i);
    sum_ext = (SUM_W+1)'(esum_q) + (SUM_W+1)'(err);
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      // saturate toward the sign of the true sum
      sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_ext[SUM_W-1:0];
    end
    diff = DIFF_W'(err) - DIFF_W'(prev_q);
    zero = (target_i == '0) && (meas_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      esum_q <= '0;
    end else if (ctrl_i.s1_en) begin
      prev_q <= err;
      esum_q <= zero ? '0 : sum_sat;
    end
  end

  assign gp = $signed({1'b0, gains_i.p});
  assign gi = $signed({1'b0, gains_i.i});
  assign gd = $signed({1'b0, gains_i.d});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s1_en) begin
      err1_q  <= err;
      sum1_q  <= sum_sat;
      diff1_q <= diff;
      zero1_q <= zero;
    end
    if (ctrl_i.s2_en) begin
      pp2_q   <= PP_W'(gp) * PP_W'(err1_q);
      pi2_q   <= PI_W'(gi) * PI_W'(sum1_q);
      pd2_q   <= PD_W'(gd) * PD_W'(diff1_q);
      zero2_q <= zero1_q;
    end
    if (ctrl_i.s3_en) begin
      acc3_q  <= ACC_W'(pp2_q) + ACC_W'(pi2_q) + ACC_W'(pd2_q);
      zero3_q <= zero2_q;
    end
  end

  // scale down with truncation toward zero, then clamp
  always_comb begin
    quot    = acc3_q >>> GAIN_FRAC_BITS;
    quot_tz = quot;
    if (acc3_q[ACC_W-1] && (acc3_q[GAIN_FRAC_BITS-1:0] != '0)) begin
      quot_tz = quot + ACC_W'(1);
    end
    if (quot_tz > LIM_HI) begin
      clamp = DRIVE_W'(DRIVE_MAX);
    end else if (quot_tz < LIM_LO) begin
      clamp = DRIVE_W'(DRIVE_MIN);
    end else begin
      clamp = quot_tz[DRIVE_W-1:0];
    end
  end

  assign drive_o = zero3_q ? '0 : clamp;

endmodule

// File: rtl/dcps_merge.sv
// Output stage: collects the drive of every lane into one result register.
// Depends on dcps_pkg.
module dcps_merge import dcps_pkg::*; #(
  parameter int CHANNELS = 2
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic [CHANNELS-1:0][DRIVE_W-1:0]       drive_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  output logic [CHANNELS*DRIVE_W-1:0]            m_axis_tdata_o
);

  logic                          valid_q;
  logic [CHANNELS*DRIVE_W-1:0]   data_q;

  assign ready_o = !valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= drive_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;

endmodule

// File: rtl/dual_channel_pid_speed.sv
// Dual-channel positional PID speed controller, top level.
// An accepted request passes error/sum, product, accumulator and output registers.
// Throughput: one request per cycle; a stage holds while the next is full and held.
// Reset: gains return to 0.3 / 0.1 / 0.05 (Q4.12), previous errors and error sums
// clear, all pipeline stages empty. No clearing pass; the block is ready at once.
// Depends on dcps_pkg, dcps_lane and dcps_merge.
module dual_channel_pid_speed import dcps_pkg::*; #(
  parameter int CHANNELS       = 2,
  parameter int MEAS_WIDTH     = 16,
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [GAIN_W-1:0]     cfg_data_i,
  // request side
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // low to high: target_speed[7:0], measured per channel (MEAS_WIDTH each), zero pad
  input  logic [((TARGET_W+CHANNELS*MEAS_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // result side
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // low to high: drive per channel, 8 bits each (drive_a, drive_b, ...)
  output logic [CHANNELS*DRIVE_W-1:0] m_axis_tdata
);

  gains_t gains_q;
  ctrl_t  ctrl;

  // stage occupancy: s1 = error/sum, s2 = products, s3 = accumulator
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3, merge_rdy;

  logic signed [TARGET_W-1:0]            target;
  logic [CHANNELS-1:0][DRIVE_W-1:0]      drives;

  // gain registers; out-of-range indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.p <= GAIN_P_RST;
      gains_q.i <= GAIN_I_RST;
      gains_q.d <= GAIN_D_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GAIN_P: gains_q.p <= cfg_data_i;
        REG_GAIN_I: gains_q.i <= cfg_data_i;
        REG_GAIN_D: gains_q.d <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Ready ripples back from the output register: a stage can load when it is
  // empty or when its content moves on in the same cycle.
  assign rdy3 = !v3_q || merge_rdy;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  assign ctrl.s1_en = s_axis_tvalid && rdy1;
  assign ctrl.s2_en = v1_q && rdy2;
  assign ctrl.s3_en = v2_q && rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  assign target = s_axis_tdata[TARGET_W-1:0];

  // one lane per channel; each keeps its own previous error and error sum
  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    dcps_lane #(
      .MEAS_WIDTH     (MEAS_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .gains_i  (gains_q),
      .target_i (target),
      .meas_i   (s_axis_tdata[TARGET_W + c*MEAS_WIDTH +: MEAS_WIDTH]),
      .drive_o  (drives[c])
    );
  end

  dcps_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (v3_q),
    .ready_o         (merge_rdy),
    .drive_i         (drives),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  // an accepted request always lands in the first stage
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v1_q)
    else $error("accepted request lost at stage 1");

  // with every stage full and the output stalled, no request may be taken
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("request taken while pipeline full");

  // stage 3 loads from stage 2 only when stage 2 holds an item
  a_s3_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.s3_en |-> v2_q)
    else $error("stage 3 loaded from empty stage");

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chk
    a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid |->
        ($signed(m_axis_tdata[c*DRIVE_W +: DRIVE_W]) <= $signed(DRIVE_W'(DRIVE_MAX)) &&
         $signed(m_axis_tdata[c*DRIVE_W +: DRIVE_W]) >= $signed(DRIVE_W'(DRIVE_MIN))))
      else $error("drive outside clamp range");
  end

endmodule
